>>> rtl/wrc_pkg.sv
package wrc_pkg;

  localparam int unsigned MAX_SEED_BYTES = 16;
  localparam int unsigned IV_BYTES       = 3;
  localparam int unsigned KEY_MAX_BYTES  = 13;
  localparam int unsigned KEY_BITS       = 8 * KEY_MAX_BYTES;

  // result kinds on m_axis_tuser[1:0]
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_ICV    = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // register indexes on the configuration port
  localparam logic [1:0] REG_KEY_LOW   = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH  = 2'd1;
  localparam logic [1:0] REG_KEY_BYTES = 2'd2;
  localparam logic [1:0] REG_KEY_INDEX = 2'd3;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

endpackage

>>> rtl/wrc_sbox_ram.sv
module wrc_sbox_ram (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic       re_i,
  input  logic [7:0] raddr_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [256];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/wrc_crc.sv
module wrc_crc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clr_i,
  input  logic        en_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);

  logic [31:0] crc_q, crc_d;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
    end
    return r;
  endfunction

  always_comb begin
    crc_d = crc_q;
    if (clr_i) begin
      crc_d = '1;
    end else if (en_i) begin
      crc_d = crc_byte(crc_q, byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '1;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

>>> rtl/wep_rc4_frame_cipher.sv
// A body byte goes from acceptance to result through five S-box memory accesses in
// sequence and the output register; one byte is in work at a time, and a new one is
// taken only once the last has left S_PUSE, which can wait while the output stalls.
// Each frame runs key scheduling (encrypt at frame start, decrypt after the fourth
// header byte): a fill of all 256 entries, then per entry reads of S[i] and S[j] and
// writes of both. Encrypt adds 4 ICV bytes. Reset clears control state, keys
// (key_bytes to 5) and the CRC; key scheduling rewrites the S-box before any use.
module wep_rc4_frame_cipher
  import wrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [7:0] data_byte, [31:8] init_vector
  input  logic [1:0]  s_axis_tuser,  // [0] operation, [1] first_of_frame
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,  // [1:0] kind, [2] icv_match
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;
  localparam logic [3:0] S_KRD_I = 4'd2;
  localparam logic [3:0] S_KRD_J = 4'd3;
  localparam logic [3:0] S_KWR_I = 4'd4;
  localparam logic [3:0] S_KWR_J = 4'd5;
  localparam logic [3:0] S_HDR   = 4'd6;
  localparam logic [3:0] S_PI    = 4'd7;
  localparam logic [3:0] S_PA    = 4'd8;
  localparam logic [3:0] S_PB    = 4'd9;
  localparam logic [3:0] S_PWJ   = 4'd10;
  localparam logic [3:0] S_PK    = 4'd11;
  localparam logic [3:0] S_PUSE  = 4'd12;
  localparam logic [3:0] S_END   = 4'd13;
  localparam logic [3:0] S_TAIL  = 4'd14;

  // configuration
  logic [63:0] key_low_q;
  logic [39:0] key_high_q;
  logic [3:0]  key_bytes_q;
  logic [1:0]  key_index_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q   <= '0;
      key_high_q  <= '0;
      key_bytes_q <= 4'd5;
      key_index_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_KEY_LOW:   key_low_q   <= pwdata;
        REG_KEY_HIGH:  key_high_q  <= pwdata[39:0];
        REG_KEY_BYTES: key_bytes_q <= pwdata[3:0];
        REG_KEY_INDEX: key_index_q <= pwdata[1:0];
        default:       key_low_q   <= key_low_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_KEY_LOW:   prdata = key_low_q;
      REG_KEY_HIGH:  prdata = {24'd0, key_high_q};
      REG_KEY_BYTES: prdata = {60'd0, key_bytes_q};
      REG_KEY_INDEX: prdata = {62'd0, key_index_q};
      default:       prdata = '0;
    endcase
  end

  // seed length in bytes
  logic [3:0] nkey;
  logic [4:0] seed_len;
  always_comb begin
    nkey = (key_bytes_q > 4'(KEY_MAX_BYTES)) ? 4'(KEY_MAX_BYTES) : key_bytes_q;
    if (5'(nkey) + 5'(IV_BYTES) > 5'(MAX_SEED_BYTES)) begin
      nkey = 4'(MAX_SEED_BYTES - IV_BYTES);
    end
    seed_len = 5'(nkey) + 5'(IV_BYTES);
  end

  function automatic logic [7:0] seed_byte(logic [23:0] iv, logic [KEY_BITS-1:0] key,
                                           logic [3:0] k);
    logic [3:0] kk;
    logic [7:0] r;
    kk = k - 4'(IV_BYTES);
    r  = 8'd0;
    if (k < 4'(IV_BYTES)) begin
      r = iv[8*k[1:0] +: 8];
    end else if (kk < 4'(KEY_MAX_BYTES)) begin
      r = key[8*kk +: 8];
    end
    return r;
  endfunction

  // state
  logic [3:0]  state_q, state_d;
  logic        active_q, active_d;
  logic        mode_q, mode_d;
  logic [2:0]  hc_q, hc_d;
  logic [23:0] iv_q, iv_d;
  logic [7:0]  i_q, i_d, j_q, j_d, n_q, n_d, a_q, a_d, b_q, b_d;
  logic [3:0]  k_q, k_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        icv_q, icv_d;
  logic [2:0]  fill_q, fill_d;
  logic [7:0]  dly_q [4];
  logic [7:0]  dly_d [4];
  logic [7:0]  d_q, d_d;
  logic        last_q, last_d;

  // S-box port
  logic       we, re;
  logic [7:0] waddr, wdata, raddr, rdata;

  // CRC
  logic        crc_clr, crc_en;
  logic [7:0]  crc_byte_in;
  logic [31:0] crc;
  logic [31:0] icv_val;

  // output register
  logic       out_free, emit;
  logic [7:0] e_byte;
  logic [1:0] e_kind;
  logic       e_match, e_last;
  logic       s_acc;

  logic [7:0] s_byte;
  logic       s_op, s_first;
  logic [7:0] jn, ks, p;
  logic [31:0] rx;

  assign s_byte  = s_axis_tdata[7:0];
  assign s_op    = s_axis_tuser[0];
  assign s_first = s_axis_tuser[1];
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign icv_val = ~crc;
  assign ks      = rdata;
  assign p       = rdata ^ d_q;
  assign rx      = {dly_q[3], dly_q[2], dly_q[1], dly_q[0]};

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    mode_d   = mode_q;
    hc_d     = hc_q;
    iv_d     = iv_q;
    i_d      = i_q;
    j_d      = j_q;
    n_d      = n_q;
    a_d      = a_q;
    b_d      = b_q;
    k_d      = k_q;
    cnt_d    = cnt_q;
    icv_d    = icv_q;
    fill_d   = fill_q;
    dly_d    = dly_q;
    d_d      = d_q;
    last_d   = last_q;
    we       = 1'b0;
    waddr    = n_q;
    wdata    = n_q;
    re       = 1'b0;
    raddr    = n_q;
    crc_clr  = 1'b0;
    crc_en   = 1'b0;
    crc_byte_in = d_q;
    emit     = 1'b0;
    e_byte   = 8'd0;
    e_kind   = KIND_BODY;
    e_match  = 1'b0;
    e_last   = 1'b0;
    jn       = j_q + rdata + seed_byte(iv_q, {key_high_q, key_low_q}, k_q);

    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          d_d    = s_byte;
          last_d = s_axis_tlast;
          if (s_first) begin
            active_d = 1'b1;
            mode_d   = s_op;
            crc_clr  = 1'b1;
            fill_d   = '0;
            for (int m = 0; m < 4; m++) dly_d[m] = '0;
            if (s_op == OP_ENCRYPT) begin
              iv_d    = s_axis_tdata[31:8];
              hc_d    = 3'd4;
              n_d     = '0;
              state_d = S_FILL;
            end else begin
              iv_d    = {16'd0, s_byte};
              hc_d    = 3'd1;
              state_d = S_END;
            end
          end else if (!active_q) begin
            state_d = S_IDLE;
          end else if (mode_q == OP_DECRYPT && hc_q < 3'd4) begin
            if (hc_q < 3'd3) iv_d[8*hc_q[1:0] +: 8] = s_byte;
            hc_d = hc_q + 3'd1;
            if (hc_q == 3'd3) begin
              n_d     = '0;
              state_d = S_FILL;
            end else begin
              state_d = S_END;
            end
          end else begin
            icv_d   = 1'b0;
            state_d = S_PI;
          end
        end
      end
      S_FILL: begin
        we = 1'b1;
        n_d = n_q + 8'd1;
        if (n_q == 8'hFF) begin
          j_d     = '0;
          k_d     = '0;
          state_d = S_KRD_I;
        end
      end
      S_KRD_I: begin
        re      = 1'b1;
        state_d = S_KRD_J;
      end
      S_KRD_J: begin
        a_d     = rdata;
        j_d     = jn;
        re      = 1'b1;
        raddr   = jn;
        state_d = S_KWR_I;
      end
      S_KWR_I: begin
        we      = 1'b1;
        wdata   = rdata;
        state_d = S_KWR_J;
      end
      S_KWR_J: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = a_q;
        k_d   = (5'(k_q) + 5'd1 >= seed_len) ? 4'd0 : k_q + 4'd1;
        n_d   = n_q + 8'd1;
        if (n_q == 8'hFF) begin
          i_d     = '0;
          j_d     = '0;
          cnt_d   = '0;
          state_d = (mode_q == OP_ENCRYPT) ? S_HDR : S_END;
        end else begin
          state_d = S_KRD_I;
        end
      end
      S_HDR: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = KIND_HEADER;
          e_byte = (cnt_q == 3'd3) ? {key_index_q, 6'd0} : iv_q[8*cnt_q[1:0] +: 8];
          cnt_d  = cnt_q + 3'd1;
          if (cnt_q == 3'd3) begin
            icv_d   = 1'b0;
            state_d = S_PI;
          end
        end
      end
      S_PI: begin
        i_d     = i_q + 8'd1;
        re      = 1'b1;
        raddr   = i_q + 8'd1;
        state_d = S_PA;
      end
      S_PA: begin
        a_d     = rdata;
        j_d     = j_q + rdata;
        re      = 1'b1;
        raddr   = j_q + rdata;
        state_d = S_PB;
      end
      S_PB: begin
        b_d     = rdata;
        we      = 1'b1;
        waddr   = i_q;
        wdata   = rdata;
        state_d = S_PWJ;
      end
      S_PWJ: begin
        we      = 1'b1;
        waddr   = j_q;
        wdata   = a_q;
        state_d = S_PK;
      end
      S_PK: begin
        re      = 1'b1;
        raddr   = a_q + b_q;
        state_d = S_PUSE;
      end
      S_PUSE: begin
        if (icv_q) begin
          if (out_free) begin
            emit   = 1'b1;
            e_kind = KIND_ICV;
            e_byte = icv_val[8*cnt_q[1:0] +: 8] ^ ks;
            e_last = (cnt_q == 3'd3);
            cnt_d  = cnt_q + 3'd1;
            state_d = (cnt_q == 3'd3) ? S_IDLE : S_PI;
          end
        end else if (mode_q == OP_ENCRYPT) begin
          if (out_free) begin
            emit    = 1'b1;
            e_byte  = p;
            crc_en  = 1'b1;
            state_d = S_END;
          end
        end else if (fill_q >= 3'd4) begin
          if (out_free) begin
            emit        = 1'b1;
            e_byte      = dly_q[0];
            crc_en      = 1'b1;
            crc_byte_in = dly_q[0];
            dly_d[0] = dly_q[1];
            dly_d[1] = dly_q[2];
            dly_d[2] = dly_q[3];
            dly_d[3] = p;
            state_d  = S_END;
          end
        end else begin
          dly_d[fill_q[1:0]] = p;
          fill_d  = fill_q + 3'd1;
          state_d = S_END;
        end
      end
      S_END: begin
        cnt_d = '0;
        if (!last_q) begin
          state_d = S_IDLE;
        end else begin
          active_d = 1'b0;
          if (mode_q == OP_ENCRYPT) begin
            icv_d   = 1'b1;
            state_d = S_PI;
          end else begin
            state_d = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          emit  = 1'b1;
          cnt_d = cnt_q + 3'd1;
          if (hc_q < 3'd4) begin
            e_kind  = KIND_STATUS;
            e_last  = 1'b1;
            state_d = S_IDLE;
          end else if (fill_q < 3'd4) begin
            if (cnt_q < fill_q) begin
              e_byte = dly_q[cnt_q[1:0]];
            end else begin
              e_kind  = KIND_STATUS;
              e_last  = 1'b1;
              state_d = S_IDLE;
            end
          end else if (cnt_q < 3'd4) begin
            e_kind = KIND_ICV;
            e_byte = dly_q[cnt_q[1:0]];
          end else begin
            e_kind  = KIND_STATUS;
            e_match = (rx == icv_val);
            e_last  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= 1'b0;
      mode_q   <= 1'b0;
      hc_q     <= '0;
      iv_q     <= '0;
      i_q      <= '0;
      j_q      <= '0;
      n_q      <= '0;
      k_q      <= '0;
      cnt_q    <= '0;
      icv_q    <= 1'b0;
      fill_q   <= '0;
      last_q   <= 1'b0;
      for (int m = 0; m < 4; m++) dly_q[m] <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      mode_q   <= mode_d;
      hc_q     <= hc_d;
      iv_q     <= iv_d;
      i_q      <= i_d;
      j_q      <= j_d;
      n_q      <= n_d;
      k_q      <= k_d;
      cnt_q    <= cnt_d;
      icv_q    <= icv_d;
      fill_q   <= fill_d;
      last_q   <= last_d;
      dly_q    <= dly_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    d_q <= d_d;
  end

  // output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_axis_tdata <= e_byte;
      m_axis_tuser <= {e_match, e_kind};
      m_axis_tlast <= e_last;
    end
  end

  wrc_sbox_ram u_sbox (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  wrc_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (crc_clr),
    .en_i   (crc_en),
    .byte_i (crc_byte_in),
    .crc_o  (crc)
  );

endmodule

>>> rtl/wrc_checker.sv
module wrc_checker
  import wrc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result dropped or changed");

  // a status closes the frame and carries no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == KIND_STATUS |-> m_axis_tlast && m_axis_tdata == 8'd0)
    else $error("status without frame end");

  // match flag only on a status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == KIND_STATUS)
    else $error("icv match flag on non-status result");

  // a frame ends on an ICV byte or a status only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tuser[1:0] == KIND_ICV || m_axis_tuser[1:0] == KIND_STATUS)
    else $error("frame ends on wrong result kind");

endmodule

bind wep_rc4_frame_cipher wrc_checker u_wrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> bench/testbench.sv
module testbench;
  import wrc_pkg::*;

  typedef struct packed {
    logic        op;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [23:0] iv;
  } byte_txn_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       match;
    logic       last;
  } cipher_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // [7:0] data_byte, [31:8] init_vector
  logic [1:0]  s_axis_tuser = '0;  // [0] operation, [1] first_of_frame
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // [7:0] out_byte
  logic [2:0]  m_axis_tuser;       // [1:0] kind, [2] icv_match
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  wep_rc4_frame_cipher dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  byte_txn_t   pending_bytes[$];
  cipher_out_t expected_out[$];
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          byte_count = 0;
  bit          failed = 1'b0;

  // configuration copy
  logic [63:0] key_lo = '0;
  logic [39:0] key_hi = '0;
  logic [3:0]  key_len = 4'd5;
  logic [1:0]  key_num = '0;

  // cipher state copy
  logic [7:0]  sbox[256];
  logic [7:0]  idx_i, idx_j;
  logic [23:0] frame_iv;
  int          hdr_cnt;
  logic [31:0] crc_acc;
  logic [7:0]  held[4];
  int          held_cnt;
  logic        frame_mode;
  bit          in_frame;

  function automatic logic [7:0] seed_at(logic [23:0] iv, int k);
    if (k < 3) return iv[8*k +: 8];
    k -= 3;
    if (k < 8) return key_lo[8*k +: 8];
    if (k < 13) return key_hi[8*(k-8) +: 8];
    return 8'h00;
  endfunction

  function automatic void rc4_schedule(ref logic [7:0] s[256], ref logic [7:0] si,
                                       ref logic [7:0] sj, input logic [23:0] iv);
    int nk, len, k;
    logic [7:0] j, t;
    nk = (key_len > 13) ? 13 : key_len;
    len = nk + 3;
    for (int n = 0; n < 256; n++) s[n] = n[7:0];
    j = 0;
    k = 0;
    for (int n = 0; n < 256; n++) begin
      j = j + s[n] + seed_at(iv, k);
      t = s[n];
      s[n] = s[j];
      s[j] = t;
      k++;
      if (k >= len) k = 0;
    end
    si = 0;
    sj = 0;
  endfunction

  function automatic logic [7:0] rc4_next(ref logic [7:0] s[256], ref logic [7:0] si,
                                          ref logic [7:0] sj);
    logic [7:0] a, b;
    si = si + 1;
    a = s[si];
    sj = sj + a;
    b = s[sj];
    s[si] = b;
    s[sj] = a;
    return s[8'(a + b)];
  endfunction

  function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] d);
    c ^= {24'h0, d};
    for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return c;
  endfunction

  function automatic void push_out(logic [7:0] d, logic [1:0] k, logic m, logic l);
    cipher_out_t r;
    r.data = d; r.kind = k; r.match = m; r.last = l;
    expected_out.push_back(r);
  endfunction

  function automatic void predict_byte(byte_txn_t t);
    logic [7:0] p;
    logic [31:0] c, rx;
    if (t.first) begin
      in_frame = 1'b1;
      frame_mode = t.op;
      crc_acc = '1;
      held_cnt = 0;
      for (int b = 0; b < 4; b++) held[b] = 8'h00;
      if (t.op == OP_ENCRYPT) begin
        frame_iv = t.iv;
        hdr_cnt = 4;
        rc4_schedule(sbox, idx_i, idx_j, frame_iv);
        push_out(frame_iv[7:0], KIND_HEADER, 1'b0, 1'b0);
        push_out(frame_iv[15:8], KIND_HEADER, 1'b0, 1'b0);
        push_out(frame_iv[23:16], KIND_HEADER, 1'b0, 1'b0);
        push_out({key_num, 6'h00}, KIND_HEADER, 1'b0, 1'b0);
      end else begin
        frame_iv = {16'h0, t.data};
        hdr_cnt = 1;
      end
    end else if (!in_frame) begin
      return;
    end else if (frame_mode == OP_DECRYPT && hdr_cnt < 4) begin
      if (hdr_cnt < 3) frame_iv[8*hdr_cnt +: 8] = t.data;
      hdr_cnt++;
      if (hdr_cnt == 4) rc4_schedule(sbox, idx_i, idx_j, frame_iv);
    end else if (frame_mode == OP_DECRYPT) begin
      p = rc4_next(sbox, idx_i, idx_j) ^ t.data;
      if (held_cnt >= 4) begin
        push_out(held[0], KIND_BODY, 1'b0, 1'b0);
        crc_acc = crc32_byte(crc_acc, held[0]);
        held[0] = held[1]; held[1] = held[2]; held[2] = held[3]; held[3] = p;
      end else begin
        held[held_cnt] = p;
        held_cnt++;
      end
    end
    if (frame_mode == OP_ENCRYPT) begin
      push_out(rc4_next(sbox, idx_i, idx_j) ^ t.data, KIND_BODY, 1'b0, 1'b0);
      crc_acc = crc32_byte(crc_acc, t.data);
    end
    if (!t.last) return;
    in_frame = 1'b0;
    if (frame_mode == OP_ENCRYPT) begin
      c = ~crc_acc;
      for (int b = 0; b < 4; b++)
        push_out(c[8*b +: 8] ^ rc4_next(sbox, idx_i, idx_j), KIND_ICV, 1'b0, b == 3);
    end else if (hdr_cnt < 4) begin
      push_out(8'h00, KIND_STATUS, 1'b0, 1'b1);
    end else if (held_cnt < 4) begin
      for (int b = 0; b < held_cnt; b++) push_out(held[b], KIND_BODY, 1'b0, 1'b0);
      push_out(8'h00, KIND_STATUS, 1'b0, 1'b1);
    end else begin
      rx = '0;
      for (int b = 0; b < 4; b++) begin
        push_out(held[b], KIND_ICV, 1'b0, 1'b0);
        rx[8*b +: 8] = held[b];
      end
      push_out(8'h00, KIND_STATUS, rx == ~crc_acc, 1'b1);
    end
  endfunction

  // monitor: predict on each accepted transaction, check each result
  always @(posedge clk_i) begin
    byte_txn_t t;
    cipher_out_t e;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        t.op = s_axis_tuser[0];
        t.first = s_axis_tuser[1];
        t.data = s_axis_tdata[7:0];
        t.iv = s_axis_tdata[31:8];
        t.last = s_axis_tlast;
        predict_byte(t);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected result data %h user %h last %b", $time,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          failed = 1'b1;
        end else begin
          e = expected_out.pop_front();
          if (m_axis_tdata !== e.data || m_axis_tuser[1:0] !== e.kind ||
              m_axis_tuser[2] !== e.match || m_axis_tlast !== e.last) begin
            $display("%0t: expected byte %h kind %0d match %b last %b, got %h %0d %b %b",
                     $time, e.data, e.kind, e.match, e.last, m_axis_tdata,
                     m_axis_tuser[1:0], m_axis_tuser[2], m_axis_tlast);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // driver: feed pending bytes, randomize the result side
  always @(posedge clk_i) begin
    byte_txn_t nxt;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {nxt.iv, nxt.data};
          s_axis_tuser <= {nxt.first, nxt.op};
          s_axis_tlast <= nxt.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_byte(logic op, logic [7:0] d, logic first, logic last, logic [23:0] iv);
    byte_txn_t t;
    t.op = op; t.data = d; t.first = first; t.last = last; t.iv = iv;
    pending_bytes.push_back(t);
    byte_count++;
  endtask

  task automatic add_encrypt(int len, logic [23:0] iv, bit ends);
    for (int k = 0; k < len; k++)
      add_byte(k == 0 ? OP_ENCRYPT : 1'($urandom), 8'($urandom), k == 0,
               ends && k == len - 1, k == 0 ? iv : 24'($urandom));
  endtask

  // well-formed received frame: header, cipher body, encrypted CRC; optional damage
  task automatic add_decrypt(int body_len, logic [23:0] iv, bit damage, bit ends);
    logic [7:0] s[256];
    logic [7:0] si, sj;
    logic [7:0] wire_bytes[$];
    logic [7:0] pt;
    logic [31:0] c;
    int pos;
    rc4_schedule(s, si, sj, iv);
    wire_bytes = '{iv[7:0], iv[15:8], iv[23:16], 8'($urandom)};
    c = '1;
    for (int k = 0; k < body_len; k++) begin
      pt = 8'($urandom);
      c = crc32_byte(c, pt);
      wire_bytes.push_back(pt ^ rc4_next(s, si, sj));
    end
    c = ~c;
    for (int b = 0; b < 4; b++) wire_bytes.push_back(c[8*b +: 8] ^ rc4_next(s, si, sj));
    if (damage) begin
      pos = $urandom_range(wire_bytes.size() - 1, 4);
      wire_bytes[pos] ^= 8'(1 << $urandom_range(7));
    end
    foreach (wire_bytes[k])
      add_byte(k == 0 ? OP_DECRYPT : 1'($urandom), wire_bytes[k], k == 0,
               ends && k == wire_bytes.size() - 1, 24'($urandom));
  endtask

  task automatic add_raw_decrypt(int len);
    for (int k = 0; k < len; k++)
      add_byte(k == 0 ? OP_DECRYPT : 1'($urandom), 8'($urandom), k == 0,
               k == len - 1, 24'($urandom));
  endtask

  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_KEY_LOW:   key_lo = val;
      REG_KEY_HIGH:  key_hi = val[39:0];
      REG_KEY_BYTES: key_len = val[3:0];
      REG_KEY_INDEX: key_num = val[1:0];
    endcase
  endtask

  task automatic drain();
    while (pending_bytes.size() > 0 || s_axis_tvalid || expected_out.size() > 0)
      @(posedge clk_i);
    // key scheduling may still run behind a silent byte
    repeat (2000) @(posedge clk_i);
  endtask

  task automatic random_frames(int target);
    int sel;
    while (byte_count < target) begin
      sel = $urandom_range(99);
      if (sel < 40) add_encrypt($urandom_range(8, 1), 24'($urandom), 1'b1);
      else if (sel < 65) add_decrypt($urandom_range(6, 0), 24'($urandom), 1'b0, 1'b1);
      else if (sel < 78) add_decrypt($urandom_range(6, 0), 24'($urandom), 1'b1, 1'b1);
      else if (sel < 85) add_raw_decrypt($urandom_range(7, 1));
      else if (sel < 92) add_byte(1'($urandom), 8'($urandom), 1'b0, 1'($urandom),
                                  24'($urandom));
      else if (sel < 96) add_encrypt($urandom_range(4, 1), 24'($urandom), 1'b0);
      else add_decrypt($urandom_range(4, 0), 24'($urandom), 1'b0, 1'b0);
    end
  endtask

  initial begin
    int target;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    in_frame = 1'b0;
    frame_mode = OP_ENCRYPT;
    hdr_cnt = 0;
    held_cnt = 0;
    crc_acc = '1;
    idx_i = 0;
    idx_j = 0;
    frame_iv = '0;

    // directed part with reset keys
    add_byte(OP_ENCRYPT, 8'hAA, 1'b0, 1'b0, 24'h123456);  // stray byte
    add_encrypt(1, 24'h000000, 1'b1);
    add_byte(OP_ENCRYPT, 8'hFF, 1'b1, 1'b1, 24'hFFFFFF);
    add_raw_decrypt(2);                                   // ends in header
    add_decrypt(0, 24'hFFFFFF, 1'b0, 1'b1);
    add_encrypt(3, 24'hA5A5A5, 1'b0);                     // cut by restart
    add_decrypt(3, 24'h5A5A5A, 1'b1, 1'b1);
    add_raw_decrypt(6);                                   // body of two bytes
    add_decrypt(2, 24'h010203, 1'b0, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          reg_write(REG_KEY_LOW, '1); reg_write(REG_KEY_HIGH, '1);
          reg_write(REG_KEY_BYTES, 64'd13); reg_write(REG_KEY_INDEX, 64'd3);
        end
        1: reg_write(REG_KEY_BYTES, 64'd15);  // clamps to 13
        2: begin
          reg_write(REG_KEY_BYTES, 64'd0); reg_write(REG_KEY_INDEX, 64'd0);
        end
        3: begin
          reg_write(REG_KEY_LOW, '0); reg_write(REG_KEY_BYTES, 64'd1);
        end
        default: begin
          reg_write(REG_KEY_LOW, {$urandom, $urandom});
          reg_write(REG_KEY_HIGH, {$urandom, $urandom});
          reg_write(REG_KEY_BYTES, 64'($urandom_range(15)));
          reg_write(REG_KEY_INDEX, 64'($urandom_range(3)));
        end
      endcase
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      target = byte_count + 50;
      random_frames(target);
      drain();
    end

    if (!failed) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
rtl/wrc_pkg.sv
rtl/wrc_sbox_ram.sv
rtl/wrc_crc.sv
rtl/wep_rc4_frame_cipher.sv
rtl/wrc_checker.sv
bench/testbench.sv
